// ===== rtl/core/ufsef_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ufsef_pkg
// Shared types and codes for the spanning-edge filter: transfer payloads,
// operation codes and sequencer states.
// ----------------------------------------------------------------------------
package ufsef_pkg;

   localparam int VERTEX_LIMIT = 1024;
   localparam int VID_W        = 10;
   localparam int VCOUNT_W     = 11;
   localparam int SIZE_W       = 11;
   localparam int WEIGHT_W     = 32;
   localparam int COST_W       = 48;
   localparam int FUNC_W       = 2;

   localparam logic [FUNC_W-1:0] FUNC_KRUSKAL = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FILTER  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [VID_W-1:0]    endpoint_a;
      logic [VID_W-1:0]    endpoint_b;
      logic [WEIGHT_W-1:0] edge_weight;
   } req_payload_type;

   typedef struct packed {
      logic              joined;
      logic              same_component;
      logic [VID_W-1:0]  tree_slot;
      logic [VID_W-1:0]  edges_left;
      logic [COST_W-1:0] cost_total;
      logic              bad_vertex;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_WALK,
      ST_COMPRESS,
      ST_SIZE_A,
      ST_SIZE_B,
      ST_FINISH
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/core/ufsef_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ufsef_req_if
// Valid/ready channel carrying one edge operation per transfer.
// ----------------------------------------------------------------------------
interface ufsef_req_if;
   logic                       valid;
   logic                       ready;
   ufsef_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ufsef_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ufsef_rsp_if
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
interface ufsef_rsp_if;
   logic                       valid;
   logic                       ready;
   ufsef_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/union_find_spanning_edge_filter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// union_find_spanning_edge_filter_unit
// Disjoint-set engine for Kruskal spanning trees: root lookup with path
// compression, union by size, saturating tree cost and edge countdown.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake     | payload
//  req_ch   | in        | valid/ready   | func, endpoint_a, endpoint_b, edge_weight
//  rsp_ch   | out       | valid/ready   | joined, same_component, tree_slot,
//           |           |               | edges_left, cost_total, bad_vertex
//  csr_*    | in        | write enable  | vertex_count (11 bits)
//
//  One item at a time. A lookup reads the parent table on the walk and again
//  on the compression pass (single read port); a query or an edge inside one
//  set skips the size steps of a union, and rejected items skip the lookup.
//  Reset, a restart item and a vertex_count write run a clearing pass over
//  the parent and size tables; no item is taken meanwhile. A result waits in
//  the output register; a stalled rsp_ch holds an item only in its final state.
// ----------------------------------------------------------------------------
module union_find_spanning_edge_filter_unit #(
   parameter int VERTICES = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [ufsef_pkg::VCOUNT_W-1:0]     csr_wdata,
   ufsef_req_if.sink                               req_ch,
   ufsef_rsp_if.source                             rsp_ch
);

   localparam int DEPTH = (VERTICES < ufsef_pkg::VERTEX_LIMIT) ?
                          VERTICES : ufsef_pkg::VERTEX_LIMIT;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [ufsef_pkg::VCOUNT_W-1:0] DEPTH_N = ufsef_pkg::VCOUNT_W'(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   // tables
   logic [AW-1:0]                 par_mem  [DEPTH];
   logic [ufsef_pkg::SIZE_W-1:0]  size_mem [DEPTH];
   logic [AW-1:0]                 par_rd_ff;
   logic [ufsef_pkg::SIZE_W-1:0]  size_rd_ff;
   logic                          par_we;
   logic [AW-1:0]                 par_wa, par_wd, par_ra;
   logic                          size_we;
   logic [AW-1:0]                 size_wa, size_ra;
   logic [ufsef_pkg::SIZE_W-1:0]  size_wd;

   // sequencer and architectural state
   ufsef_pkg::state_type              state_ff, state_in;
   logic [AW-1:0]                     clr_ff, clr_in;
   logic                              reply_ff, reply_in;
   logic [ufsef_pkg::VCOUNT_W-1:0]    vcount_ff;
   logic [ufsef_pkg::VID_W-1:0]       edges_ff, edges_in;
   logic [ufsef_pkg::COST_W-1:0]      cost_ff, cost_in;

   // item working registers
   logic [ufsef_pkg::FUNC_W-1:0]      func_ff, func_in;
   logic [AW-1:0]                     a_idx_ff, a_idx_in, b_idx_ff, b_idx_in;
   logic [ufsef_pkg::WEIGHT_W-1:0]    weight_ff, weight_in;
   logic                              phase_ff, phase_in;
   logic [AW-1:0]                     cur_ff, cur_in;
   logic [AW-1:0]                     root_ff, root_in, root_a_ff, root_a_in;
   logic [ufsef_pkg::SIZE_W-1:0]      size_a_ff, size_a_in;
   logic                              joined_ff, joined_in, same_ff, same_in;
   logic                              bad_ff, bad_in;
   logic [ufsef_pkg::VID_W-1:0]       slot_ff, slot_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   ufsef_pkg::rsp_payload_type        rsp_data_ff, rsp_data_in;

   // helpers
   logic [ufsef_pkg::VCOUNT_W-1:0]    n_act, n_csr;
   logic [ufsef_pkg::VID_W-1:0]       edges_rst, edges_csr;
   logic                              req_fire, rsp_free, is_bad, is_lookup;
   logic [AW-1:0]                     start_idx;
   logic [ufsef_pkg::SIZE_W-1:0]      size_sum;
   logic [ufsef_pkg::COST_W:0]        cost_sum;
   logic [ufsef_pkg::VID_W-1:0]       edges_dec;

   assign n_act     = (vcount_ff > DEPTH_N) ? DEPTH_N : vcount_ff;
   assign n_csr     = (csr_wdata > DEPTH_N) ? DEPTH_N : csr_wdata;
   assign edges_rst = (n_act == '0) ? '0 : ufsef_pkg::VID_W'(n_act - 1'b1);
   assign edges_csr = (n_csr == '0) ? '0 : ufsef_pkg::VID_W'(n_csr - 1'b1);

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   assign is_lookup = (req_ch.data.func == ufsef_pkg::FUNC_KRUSKAL) ||
                      (req_ch.data.func == ufsef_pkg::FUNC_FILTER);
   assign is_bad    = is_lookup &&
                      ((ufsef_pkg::VCOUNT_W'(req_ch.data.endpoint_a) >= n_act) ||
                       (ufsef_pkg::VCOUNT_W'(req_ch.data.endpoint_b) >= n_act));
   assign start_idx = phase_ff ? b_idx_ff : a_idx_ff;
   assign size_sum  = size_a_ff + size_rd_ff;
   assign cost_sum  = {1'b0, cost_ff} + (ufsef_pkg::COST_W + 1)'(weight_ff);
   assign edges_dec = edges_ff - 1'b1;

   assign req_ch.ready = (state_ff == ufsef_pkg::ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ufsef_pkg::ST_IDLE: begin
            if (req_fire) begin
               priority if (req_ch.data.func == ufsef_pkg::FUNC_RESTART)
                  state_in = ufsef_pkg::ST_CLEAR;
               else if (!is_lookup || is_bad)
                  state_in = ufsef_pkg::ST_FINISH;
               else if ((req_ch.data.func == ufsef_pkg::FUNC_KRUSKAL) && (edges_ff == '0))
                  state_in = ufsef_pkg::ST_FINISH;
               else
                  state_in = ufsef_pkg::ST_WALK;
            end
         end
         ufsef_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_IDX)
               state_in = reply_ff ? ufsef_pkg::ST_FINISH : ufsef_pkg::ST_IDLE;
         end
         ufsef_pkg::ST_WALK: begin
            if (par_rd_ff == cur_ff) state_in = ufsef_pkg::ST_COMPRESS;
         end
         ufsef_pkg::ST_COMPRESS: begin
            if (cur_ff == root_ff) begin
               priority if (!phase_ff)
                  state_in = ufsef_pkg::ST_WALK;
               else if ((func_ff == ufsef_pkg::FUNC_FILTER) || (root_a_ff == root_ff))
                  state_in = ufsef_pkg::ST_FINISH;
               else
                  state_in = ufsef_pkg::ST_SIZE_A;
            end
         end
         ufsef_pkg::ST_SIZE_A:  state_in = ufsef_pkg::ST_SIZE_B;
         ufsef_pkg::ST_SIZE_B:  state_in = ufsef_pkg::ST_FINISH;
         ufsef_pkg::ST_FINISH: begin
            if (rsp_free) state_in = ufsef_pkg::ST_IDLE;
         end
         default:               state_in = ufsef_pkg::ST_IDLE;
      endcase
      if (csr_we) state_in = ufsef_pkg::ST_CLEAR;
   end

   // datapath and table control
   always_comb begin
      clr_in       = clr_ff;
      reply_in     = reply_ff;
      edges_in     = edges_ff;
      cost_in      = cost_ff;
      func_in      = func_ff;
      a_idx_in     = a_idx_ff;
      b_idx_in     = b_idx_ff;
      weight_in    = weight_ff;
      phase_in     = phase_ff;
      cur_in       = cur_ff;
      root_in      = root_ff;
      root_a_in    = root_a_ff;
      size_a_in    = size_a_ff;
      joined_in    = joined_ff;
      same_in      = same_ff;
      bad_in       = bad_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      par_we       = 1'b0;
      par_wa       = cur_ff;
      par_wd       = root_ff;
      par_ra       = cur_ff;
      size_we      = 1'b0;
      size_wa      = root_ff;
      size_wd      = size_sum;
      size_ra      = root_ff;

      unique case (state_ff)
         ufsef_pkg::ST_IDLE: begin
            par_ra = AW'(req_ch.data.endpoint_a);
            if (req_fire) begin
               func_in   = req_ch.data.func;
               a_idx_in  = AW'(req_ch.data.endpoint_a);
               b_idx_in  = AW'(req_ch.data.endpoint_b);
               weight_in = req_ch.data.edge_weight;
               phase_in  = 1'b0;
               cur_in    = AW'(req_ch.data.endpoint_a);
               joined_in = 1'b0;
               same_in   = 1'b0;
               slot_in   = '0;
               bad_in    = is_bad;
               if (req_ch.data.func == ufsef_pkg::FUNC_RESTART) begin
                  edges_in = edges_rst;
                  cost_in  = '0;
                  clr_in   = '0;
                  reply_in = 1'b1;
               end
            end
         end
         ufsef_pkg::ST_CLEAR: begin
            par_we  = 1'b1;
            par_wa  = clr_ff;
            par_wd  = clr_ff;
            size_we = 1'b1;
            size_wa = clr_ff;
            size_wd = ufsef_pkg::SIZE_W'(1);
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) reply_in = 1'b0;
         end
         ufsef_pkg::ST_WALK: begin
            if (par_rd_ff == cur_ff) begin
               root_in = cur_ff;
               cur_in  = start_idx;
               par_ra  = start_idx;
            end else begin
               cur_in  = par_rd_ff;
               par_ra  = par_rd_ff;
            end
         end
         ufsef_pkg::ST_COMPRESS: begin
            if (cur_ff != root_ff) begin
               // point this vertex straight at the root and step on
               par_we = 1'b1;
               par_wa = cur_ff;
               par_wd = root_ff;
               cur_in = par_rd_ff;
               par_ra = par_rd_ff;
            end else if (!phase_ff) begin
               root_a_in = root_ff;
               phase_in  = 1'b1;
               cur_in    = b_idx_ff;
               par_ra    = b_idx_ff;
            end else begin
               same_in = (root_a_ff == root_ff);
               size_ra = root_a_ff;
            end
         end
         ufsef_pkg::ST_SIZE_A: begin
            size_a_in = size_rd_ff;
            size_ra   = root_ff;
         end
         ufsef_pkg::ST_SIZE_B: begin
            // smaller tree goes under the larger, b under a on a tie
            par_we  = 1'b1;
            size_we = 1'b1;
            size_wd = size_sum;
            if (size_a_ff < size_rd_ff) begin
               par_wa  = root_a_ff;
               par_wd  = root_ff;
               size_wa = root_ff;
            end else begin
               par_wa  = root_ff;
               par_wd  = root_a_ff;
               size_wa = root_a_ff;
            end
            cost_in   = cost_sum[ufsef_pkg::COST_W] ? '1 : cost_sum[ufsef_pkg::COST_W-1:0];
            edges_in  = edges_dec;
            slot_in   = edges_dec;
            joined_in = 1'b1;
         end
         ufsef_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.joined         = joined_ff;
               rsp_data_in.same_component = same_ff;
               rsp_data_in.tree_slot      = slot_ff;
               rsp_data_in.edges_left     = edges_ff;
               rsp_data_in.cost_total     = cost_ff;
               rsp_data_in.bad_vertex     = bad_ff;
            end
         end
         default: begin
            par_we = 1'b0;
         end
      endcase

      if (csr_we) begin
         edges_in = edges_csr;
         cost_in  = '0;
         clr_in   = '0;
         reply_in = 1'b0;
      end
   end

   // parent and size tables, registered read
   always_ff @(posedge clock) begin
      if (par_we) par_mem[par_wa] <= par_wd;
      par_rd_ff <= par_mem[par_ra];
   end

   always_ff @(posedge clock) begin
      if (size_we) size_mem[size_wa] <= size_wd;
      size_rd_ff <= size_mem[size_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ufsef_pkg::ST_CLEAR;
         clr_ff       <= '0;
         reply_ff     <= 1'b0;
         vcount_ff    <= ufsef_pkg::VCOUNT_W'(ufsef_pkg::VERTEX_LIMIT);
         edges_ff     <= ufsef_pkg::VID_W'(DEPTH - 1);
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         reply_ff     <= reply_in;
         if (csr_we) vcount_ff <= csr_wdata;
         edges_ff     <= edges_in;
         cost_ff      <= cost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      a_idx_ff    <= a_idx_in;
      b_idx_ff    <= b_idx_in;
      weight_ff   <= weight_in;
      phase_ff    <= phase_in;
      cur_ff      <= cur_in;
      root_ff     <= root_in;
      root_a_ff   <= root_a_in;
      size_a_ff   <= size_a_in;
      joined_ff   <= joined_in;
      same_ff     <= same_in;
      bad_ff      <= bad_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   a_no_take_during_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ufsef_pkg::ST_CLEAR) |-> !req_ch.ready)
      else $error("item taken during table clear");

   a_compress_no_self_loop: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ufsef_pkg::ST_COMPRESS) && par_we) |-> (par_wa != par_wd))
      else $error("compression rewrote a root");

   a_joined_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.data.joined) |->
         (!rsp_ch.data.same_component && !rsp_ch.data.bad_vertex &&
          (rsp_ch.data.tree_slot == rsp_ch.data.edges_left)))
      else $error("joined result inconsistent");

   a_cost_monotonic: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ufsef_pkg::ST_SIZE_B) && !csr_we) |=> (cost_ff >= $past(cost_ff)))
      else $error("tree cost went down on a union");

endmodule
`default_nettype wire
